### rtl/tdc_pkg.sv
// shared types, command codes and character helpers for the time-of-day clock
package tdc_pkg;

   localparam logic [1:0] CMD_TICK  = 2'd0;
   localparam logic [1:0] CMD_RESET = 2'd1;
   localparam logic [1:0] CMD_SET   = 2'd2;
   localparam logic [1:0] CMD_STOP  = 2'd3;

   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_SPACE = 8'h20;

   localparam logic [3:0] MAX_HOUR_TENS   = 4'd2;
   localparam logic [3:0] MAX_HOUR_ONES   = 4'd3;
   localparam logic [3:0] MAX_SIXTY_TENS  = 4'd5;
   localparam logic [3:0] MAX_DIGIT       = 4'd9;

   typedef struct packed {
      logic [1:0] req_type;
      logic [7:0] sep_space;
      logic [7:0] hour_tens_char;
      logic [7:0] hour_ones_char;
      logic [7:0] sep_colon_a;
      logic [7:0] minute_tens_char;
      logic [7:0] minute_ones_char;
      logic [7:0] sep_colon_b;
      logic [7:0] second_tens_char;
      logic [7:0] second_ones_char;
   } tdc_req_type;

   typedef struct packed {
      logic [5:0] out_hour_tens;
      logic [5:0] out_hour_ones;
      logic [5:0] out_minute_tens;
      logic [5:0] out_minute_ones;
      logic [5:0] out_second_tens;
      logic [5:0] out_second_ones;
   } tdc_rsp_type;

   // time of day kept as decimal digits
   typedef struct packed {
      logic [1:0] hour_tens;
      logic [3:0] hour_ones;
      logic [2:0] minute_tens;
      logic [3:0] minute_ones;
      logic [2:0] second_tens;
      logic [3:0] second_ones;
   } tdc_time_type;

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= CH_ZERO) && (c <= CH_NINE);
   endfunction

   // ascii '0'..'9' is 0x30 | digit, six bits wide
   function automatic logic [5:0] to_ascii(input logic [3:0] d);
      return {2'b11, d};
   endfunction

endpackage

### rtl/tdc_stream_if.sv
// valid/ready stream channel carrying one payload per beat
interface tdc_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

### rtl/time_of_day_clock_unit.sv
// time-of-day clock: tick, reset, set and stop commands, reports hh mm ss as ascii
// a request beat is registered in the request stage, any response beat in the response register
// throughput: one request beat per cycle; the request input stalls only when the
//   request stage is full and the response register is full and not being taken
// reset: synchronous, clears the time to 00:00:00 and starts the clock, no beat pending
module time_of_day_clock_unit
   import tdc_pkg::*;
(
   input logic            clock,
   input logic            reset,
   tdc_stream_if.sink     req_chan,
   tdc_stream_if.source   rsp_chan
);

   logic         req_valid_ff, req_valid_in;
   tdc_req_type  req_data_ff,  req_data_in;
   tdc_time_type time_ff,      time_in;
   logic         running_ff,   running_in;
   logic         rsp_valid_ff, rsp_valid_in;
   tdc_rsp_type  rsp_data_ff,  rsp_data_in;

   logic         out_free;
   logic         advance;
   logic         req_take;
   logic         emit;
   tdc_time_type tick_time;
   tdc_time_type set_time;
   logic         set_ok;
   logic [3:0]   ht_d, ho_d, mt_d, mo_d, st_d, so_d;

   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   assign advance        = req_valid_ff && out_free;
   assign req_chan.ready = !req_valid_ff || out_free;
   assign req_take       = req_chan.valid && req_chan.ready;

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.data  = rsp_data_ff;

   // one-second advance with decimal carries
   always_comb begin
      tick_time = time_ff;
      if (time_ff.second_ones == MAX_DIGIT) begin
         tick_time.second_ones = '0;
         if (time_ff.second_tens == MAX_SIXTY_TENS[2:0]) begin
            tick_time.second_tens = '0;
            if (time_ff.minute_ones == MAX_DIGIT) begin
               tick_time.minute_ones = '0;
               if (time_ff.minute_tens == MAX_SIXTY_TENS[2:0]) begin
                  tick_time.minute_tens = '0;
                  if (time_ff.hour_tens == MAX_HOUR_TENS[1:0] &&
                      time_ff.hour_ones == MAX_HOUR_ONES) begin
                     tick_time.hour_tens = '0;
                     tick_time.hour_ones = '0;
                  end else if (time_ff.hour_ones == MAX_DIGIT) begin
                     tick_time.hour_ones = '0;
                     tick_time.hour_tens = time_ff.hour_tens + 2'd1;
                  end else begin
                     tick_time.hour_ones = time_ff.hour_ones + 4'd1;
                  end
               end else begin
                  tick_time.minute_tens = time_ff.minute_tens + 3'd1;
               end
            end else begin
               tick_time.minute_ones = time_ff.minute_ones + 4'd1;
            end
         end else begin
            tick_time.second_tens = time_ff.second_tens + 3'd1;
         end
      end else begin
         tick_time.second_ones = time_ff.second_ones + 4'd1;
      end
   end

   // parse " hh:mm:ss"
   assign ht_d = req_data_ff.hour_tens_char[3:0];
   assign ho_d = req_data_ff.hour_ones_char[3:0];
   assign mt_d = req_data_ff.minute_tens_char[3:0];
   assign mo_d = req_data_ff.minute_ones_char[3:0];
   assign st_d = req_data_ff.second_tens_char[3:0];
   assign so_d = req_data_ff.second_ones_char[3:0];

   assign set_ok = (req_data_ff.sep_space   == CH_SPACE) &&
                   (req_data_ff.sep_colon_a == CH_COLON) &&
                   (req_data_ff.sep_colon_b == CH_COLON) &&
                   is_digit(req_data_ff.hour_tens_char) &&
                   is_digit(req_data_ff.hour_ones_char) &&
                   is_digit(req_data_ff.minute_tens_char) &&
                   is_digit(req_data_ff.minute_ones_char) &&
                   is_digit(req_data_ff.second_tens_char) &&
                   is_digit(req_data_ff.second_ones_char) &&
                   (ht_d <= MAX_HOUR_TENS) &&
                   (ht_d != MAX_HOUR_TENS || ho_d <= MAX_HOUR_ONES) &&
                   (mt_d <= MAX_SIXTY_TENS) &&
                   (st_d <= MAX_SIXTY_TENS);

   assign set_time.hour_tens   = ht_d[1:0];
   assign set_time.hour_ones   = ho_d;
   assign set_time.minute_tens = mt_d[2:0];
   assign set_time.minute_ones = mo_d;
   assign set_time.second_tens = st_d[2:0];
   assign set_time.second_ones = so_d;

   always_comb begin
      time_in    = time_ff;
      running_in = running_ff;
      emit       = 1'b0;
      if (advance) begin
         unique case (req_data_ff.req_type)
            CMD_TICK: begin
               if (running_ff) begin
                  time_in = tick_time;
                  emit    = 1'b1;
               end
            end
            CMD_RESET: begin
               time_in    = '0;
               running_in = 1'b1;
               emit       = 1'b1;
            end
            CMD_SET: begin
               if (set_ok) begin
                  time_in    = set_time;
                  running_in = 1'b1;
                  emit       = 1'b1;
               end
            end
            CMD_STOP: begin
               time_in    = '0;
               running_in = 1'b0;
            end
            default: begin
               time_in = time_ff;
            end
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (emit) begin
         rsp_valid_in                = 1'b1;
         rsp_data_in.out_hour_tens   = to_ascii({2'b00, time_in.hour_tens});
         rsp_data_in.out_hour_ones   = to_ascii(time_in.hour_ones);
         rsp_data_in.out_minute_tens = to_ascii({1'b0, time_in.minute_tens});
         rsp_data_in.out_minute_ones = to_ascii(time_in.minute_ones);
         rsp_data_in.out_second_tens = to_ascii({1'b0, time_in.second_tens});
         rsp_data_in.out_second_ones = to_ascii(time_in.second_ones);
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_comb begin
      req_valid_in = req_valid_ff;
      req_data_in  = req_data_ff;
      if (req_take) begin
         req_valid_in = 1'b1;
         req_data_in  = req_chan.data;
      end else if (advance) begin
         req_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         time_ff      <= '0;
         running_ff   <= 1'b1;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         time_ff      <= time_in;
         running_ff   <= running_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      req_data_ff <= req_data_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule
